[design/csem_pkg.sv]
// Package for the counting semaphore table: sizes, command codes, beat types,
// controller states and the count saturation helper.
// Depends on nothing; every other file of the block imports it.
package csem_pkg;

	localparam int SLOTS      = 32;
	localparam int TASKS      = 64;
	localparam int COUNT_BITS = 16;
	localparam int REF_BITS   = 8;
	localparam int SLOT_W     = $clog2(SLOTS);
	localparam int TASK_W     = $clog2(TASKS);

	localparam logic [2:0] CMD_OPEN_NAMED = 3'd0;
	localparam logic [2:0] CMD_OPEN_FREE  = 3'd1;
	localparam logic [2:0] CMD_CLOSE      = 3'd2;
	localparam logic [2:0] CMD_WAIT       = 3'd3;
	localparam logic [2:0] CMD_POST       = 3'd4;

	localparam logic signed [33:0] CNT_MAX = 34'((64'sd1 <<< (COUNT_BITS - 1)) - 64'sd1);
	localparam logic signed [33:0] CNT_MIN = -CNT_MAX - 34'sd1;

	typedef struct packed {
		logic [2:0]         command;
		logic [4:0]         sem_index;
		logic signed [15:0] initial_count;
		logic [5:0]         task_id;
	} sem_req_t;

	typedef struct packed {
		logic       error;
		logic [4:0] slot_id;
		logic       blocked;
		logic       woken_valid;
		logic [5:0] woken_task;
	} sem_rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_EXEC
	} ctrl_state_t;

	typedef struct packed {
		logic capture;
		logic load;
		logic exec;
	} dp_cmd_t;

	function automatic logic signed [COUNT_BITS-1:0] sat_cnt(input logic signed [33:0] v);
		logic signed [33:0] r;
		if (v > CNT_MAX) begin
			r = CNT_MAX;
		end else if (v < CNT_MIN) begin
			r = CNT_MIN;
		end else begin
			r = v;
		end
		return COUNT_BITS'(r);
	endfunction

endpackage

[design/counting_semaphore_table_core.sv]
// Top level of the counting semaphore table.
// Depends on csem_pkg, csem_ctrl and csem_dp.
//
// A request beat is taken at a rising edge where start is high and busy is low.
// The request carries the command, the slot index, the starting count for the
// open commands and the calling task. Every request gives exactly one result
// beat, shown on result for one cycle while done is high.
// Each request walks three controller states: capture, table read with the
// free-slot and waiter match scans, then the update and result write. The
// result is registered in the update state and busy is low again while done
// is high, so a new request is taken only once the last result is shown.
// The free-slot and lowest-waiter searches are registered match vectors that
// a priority encoder resolves in the update cycle.
// Reset clears every count, reference count and waiting mark at once, so the
// block takes a request as soon as reset is released.
// The receiver cannot stall: each result must be taken in its one cycle.
module counting_semaphore_table_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  csem_pkg::sem_req_t request,
	output logic               done,
	output csem_pkg::sem_rsp_t result
);
	import csem_pkg::*;

	dp_cmd_t dp_cmd;

	csem_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.dp_cmd (dp_cmd)
	);

	csem_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.dp_cmd  (dp_cmd),
		.request (request),
		.done    (done),
		.result  (result)
	);

endmodule

[design/csem_ctrl.sv]
// Controller state machine of the counting semaphore table.
// Depends on csem_pkg; drives the datapath through a dp_cmd_t command group.
module csem_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	output csem_pkg::dp_cmd_t dp_cmd
);
	import csem_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		dp_cmd  = '0;
		busy    = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					dp_cmd.capture = 1'b1;
					state_d        = ST_LOAD;
				end
			end
			ST_LOAD: begin
				dp_cmd.load = 1'b1;
				state_d     = ST_EXEC;
			end
			ST_EXEC: begin
				dp_cmd.exec = 1'b1;
				state_d     = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

[design/csem_dp.sv]
// Datapath of the counting semaphore table: semaphore and task tables, the
// free-slot and waiter scans, and the result register.
// Depends on csem_pkg; sequenced by csem_ctrl through a dp_cmd_t group.
module csem_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  csem_pkg::dp_cmd_t  dp_cmd,
	input  csem_pkg::sem_req_t request,
	output logic               done,
	output csem_pkg::sem_rsp_t result
);
	import csem_pkg::*;

	sem_req_t                      req_q;
	logic signed [COUNT_BITS-1:0]  sem_count_q [SLOTS];
	logic [REF_BITS-1:0]           refs_q [SLOTS];
	logic [TASKS-1:0]              waiting_q;
	logic [SLOT_W-1:0]             wait_slot_q [TASKS];

	logic signed [COUNT_BITS-1:0]  cnt_s1;
	logic [REF_BITS-1:0]           refs_s1;
	logic [SLOTS-1:0]              free_s1;
	logic [TASKS-1:0]              match_s1;

	sem_rsp_t                      rsp_q;
	logic                          done_q;

	logic [SLOT_W-1:0]             idx;
	logic [TASK_W-1:0]             tidx;
	logic                          idx_ok;
	logic                          task_ok;
	logic [SLOTS-1:0]              free_vec;
	logic [TASKS-1:0]              match_vec;
	logic [SLOT_W-1:0]             free_idx;
	logic [TASK_W-1:0]             wake_idx;
	logic signed [COUNT_BITS-1:0]  init_sat;
	logic signed [COUNT_BITS-1:0]  cnt_dec;
	logic signed [COUNT_BITS-1:0]  cnt_inc;

	sem_rsp_t                      rsp_d;
	logic                          wr_en;
	logic [SLOT_W-1:0]             wr_slot;
	logic signed [COUNT_BITS-1:0]  wr_cnt;
	logic [REF_BITS-1:0]           wr_refs;
	logic                          set_wait;
	logic                          clr_wait;

	function automatic logic [SLOT_W-1:0] first_slot(input logic [SLOTS-1:0] v);
		logic [SLOT_W-1:0] r;
		r = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (v[i]) r = SLOT_W'(i);
		end
		return r;
	endfunction

	function automatic logic [TASK_W-1:0] first_task(input logic [TASKS-1:0] v);
		logic [TASK_W-1:0] r;
		r = '0;
		for (int i = TASKS - 1; i >= 0; i--) begin
			if (v[i]) r = TASK_W'(i);
		end
		return r;
	endfunction

	assign idx     = SLOT_W'(req_q.sem_index);
	assign tidx    = TASK_W'(req_q.task_id);
	assign idx_ok  = 32'(req_q.sem_index) < SLOTS;
	assign task_ok = 32'(req_q.task_id) < TASKS;

	always_comb begin
		for (int i = 0; i < SLOTS; i++) begin
			free_vec[i] = (refs_q[i] == '0);
		end
		for (int t = 0; t < TASKS; t++) begin
			match_vec[t] = waiting_q[t] && (wait_slot_q[t] == idx);
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.capture) begin
			req_q <= request;
		end
		if (dp_cmd.load) begin
			cnt_s1   <= sem_count_q[idx];
			refs_s1  <= refs_q[idx];
			free_s1  <= free_vec;
			match_s1 <= match_vec;
		end
	end

	assign free_idx = first_slot(free_s1);
	assign wake_idx = first_task(match_s1);
	assign init_sat = sat_cnt(34'(req_q.initial_count));
	assign cnt_dec  = sat_cnt(34'(cnt_s1) - 34'sd1);
	assign cnt_inc  = sat_cnt(34'(cnt_s1) + 34'sd1);

	always_comb begin
		rsp_d    = '0;
		wr_en    = 1'b0;
		wr_slot  = idx;
		wr_cnt   = cnt_s1;
		wr_refs  = refs_s1;
		set_wait = 1'b0;
		clr_wait = 1'b0;
		if (req_q.command == CMD_OPEN_FREE) begin
			if (|free_s1) begin
				wr_en         = 1'b1;
				wr_slot       = free_idx;
				wr_refs       = REF_BITS'(1);
				wr_cnt        = init_sat;
				rsp_d.slot_id = 5'(free_idx);
			end else begin
				rsp_d.error = 1'b1;
			end
		end else if (!idx_ok) begin
			rsp_d.error = 1'b1;
		end else begin
			case (req_q.command)
				CMD_OPEN_NAMED: begin
					wr_en         = 1'b1;
					rsp_d.slot_id = req_q.sem_index;
					if (refs_s1 != '0) begin
						if (refs_s1 != '1) wr_refs = refs_s1 + REF_BITS'(1);
					end else begin
						wr_refs = REF_BITS'(1);
						wr_cnt  = init_sat;
					end
				end
				CMD_CLOSE: begin
					if (refs_s1 == '0) begin
						rsp_d.error = 1'b1;
					end else begin
						wr_en         = 1'b1;
						wr_refs       = refs_s1 - REF_BITS'(1);
						wr_cnt        = '0;
						rsp_d.slot_id = req_q.sem_index;
					end
				end
				CMD_WAIT: begin
					wr_en         = 1'b1;
					wr_cnt        = cnt_dec;
					rsp_d.slot_id = req_q.sem_index;
					if (cnt_dec < 0) begin
						rsp_d.blocked = 1'b1;
						set_wait      = task_ok;
					end
				end
				CMD_POST: begin
					wr_en         = 1'b1;
					wr_cnt        = cnt_inc;
					rsp_d.slot_id = req_q.sem_index;
					if ((cnt_inc <= 0) && (|match_s1)) begin
						clr_wait          = 1'b1;
						rsp_d.woken_valid = 1'b1;
						rsp_d.woken_task  = 6'(wake_idx);
					end
				end
				default: begin
					rsp_d.error = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				sem_count_q[i] <= '0;
				refs_q[i]      <= '0;
			end
			waiting_q <= '0;
			done_q    <= 1'b0;
		end else begin
			done_q <= dp_cmd.exec;
			if (dp_cmd.exec) begin
				if (wr_en) begin
					sem_count_q[wr_slot] <= wr_cnt;
					refs_q[wr_slot]      <= wr_refs;
				end
				if (set_wait) waiting_q[tidx] <= 1'b1;
				if (clr_wait) waiting_q[wake_idx] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.exec) begin
			rsp_q <= rsp_d;
			if (set_wait) wait_slot_q[tidx] <= idx;
		end
	end

	assign done   = done_q;
	assign result = rsp_q;

endmodule

[tb/tb_counting_semaphore_table_core.sv]
// Self-checking testbench for counting_semaphore_table_core: drives command beats in random
// bursts, keeps its own copy of the semaphore and waiter tables to predict each result beat,
// and compares every result field. Depends on csem_pkg and the RTL of the core only.
`timescale 1ns / 1ps

module tb_counting_semaphore_table_core;
	import csem_pkg::*;

	localparam logic [2:0] CMD_RSVD_LO  = 3'd5;
	localparam logic [2:0] CMD_RSVD_HI  = 3'd7;
	localparam int         IDLE_LIMIT   = 2000;
	localparam int         RANDOM_ITEMS = 950;

	logic     clk;
	logic     arst_n;
	logic     start;
	logic     busy;
	logic     done;
	sem_req_t request;
	sem_rsp_t result;

	logic signed [COUNT_BITS-1:0] count_tbl [SLOTS];
	logic [REF_BITS-1:0]          refs_tbl [SLOTS];
	logic                         waiting_tbl [TASKS];
	logic [SLOT_W-1:0]            wait_slot_tbl [TASKS];

	sem_rsp_t rsp_due [$];
	sem_rsp_t want_rsp;
	int       n_sent;
	int       n_rsp;
	int       n_blocked;
	int       n_woken;
	int       n_err_rsp;
	int       n_mismatch;
	int       idle_cycles;
	int       burst_left;

	counting_semaphore_table_core i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.request (request),
		.done    (done),
		.result  (result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic signed [COUNT_BITS-1:0] clamp_count(input int v);
		int hi;
		int lo;
		hi = (1 <<< (COUNT_BITS - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) begin
			v = hi;
		end else if (v < lo) begin
			v = lo;
		end
		return v[COUNT_BITS-1:0];
	endfunction

	// Updates the shadow tables for one command and returns the result it must produce.
	function automatic sem_rsp_t apply_command(input sem_req_t r);
		sem_rsp_t          rsp;
		logic [SLOT_W-1:0] idx;
		logic [TASK_W-1:0] tid;
		rsp = '0;
		idx = r.sem_index;
		tid = r.task_id;
		case (r.command)
			CMD_OPEN_FREE: begin
				rsp.error = 1'b1;
				for (int i = 0; i < SLOTS; i++) begin
					if (refs_tbl[i] == 0) begin
						refs_tbl[i]   = REF_BITS'(1);
						count_tbl[i]  = clamp_count(int'(r.initial_count));
						rsp.slot_id   = 5'(i);
						rsp.error     = 1'b0;
						break;
					end
				end
			end
			CMD_OPEN_NAMED: begin
				if (refs_tbl[idx] != 0) begin
					if (refs_tbl[idx] != '1) begin
						refs_tbl[idx] = refs_tbl[idx] + REF_BITS'(1);
					end
				end else begin
					refs_tbl[idx]  = REF_BITS'(1);
					count_tbl[idx] = clamp_count(int'(r.initial_count));
				end
				rsp.slot_id = idx;
			end
			CMD_CLOSE: begin
				if (refs_tbl[idx] == 0) begin
					rsp.error = 1'b1;
				end else begin
					refs_tbl[idx]  = refs_tbl[idx] - REF_BITS'(1);
					count_tbl[idx] = '0;
					rsp.slot_id    = idx;
				end
			end
			CMD_WAIT: begin
				count_tbl[idx] = clamp_count(int'(count_tbl[idx]) - 1);
				if (count_tbl[idx] < 0) begin
					rsp.blocked = 1'b1;
					if (32'(tid) < TASKS) begin
						waiting_tbl[tid]   = 1'b1;
						wait_slot_tbl[tid] = idx;
					end
				end
				rsp.slot_id = idx;
			end
			CMD_POST: begin
				count_tbl[idx] = clamp_count(int'(count_tbl[idx]) + 1);
				if (count_tbl[idx] <= 0) begin
					for (int i = 0; i < TASKS; i++) begin
						if (waiting_tbl[i] && wait_slot_tbl[i] == idx) begin
							waiting_tbl[i]  = 1'b0;
							rsp.woken_valid = 1'b1;
							rsp.woken_task  = 6'(i);
							break;
						end
					end
				end
				rsp.slot_id = idx;
			end
			default: begin
				rsp.error = 1'b1;
			end
		endcase
		if (rsp.error) begin
			rsp.slot_id = '0;
		end
		return rsp;
	endfunction

	function automatic sem_req_t build_req(input logic [2:0] cmd, input int idx, input int init,
		input int tid);
		sem_req_t r;
		r.command       = cmd;
		r.sem_index     = 5'(idx);
		r.initial_count = 16'(init);
		r.task_id       = 6'(tid);
		return r;
	endfunction

	function automatic logic signed [15:0] rand_count();
		case ($urandom_range(0, 7))
			0: begin
				return 16'sh8000;
			end
			1: begin
				return 16'sh7FFF;
			end
			2, 3, 4, 5: begin
				return 16'(int'($urandom_range(0, 5)) - 2);
			end
			default: begin
				return 16'($urandom());
			end
		endcase
	endfunction

	// Sends one command beat and records its expected result; gaps between bursts are random.
	task automatic issue_command(input sem_req_t r);
		int gap;
		@(negedge clk);
		start   <= 1'b1;
		request <= r;
		do @(posedge clk); while (busy);
		rsp_due.push_back(apply_command(r));
		n_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = $urandom_range(1, 6);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
				: $urandom_range(0, 8);
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic drain_results();
		@(negedge clk);
		start <= 1'b0;
		while (rsp_due.size() != 0) @(posedge clk);
	endtask

	task automatic test_directed_cases();
		issue_command(build_req(CMD_OPEN_NAMED, SLOTS - 1, 32767, TASKS - 1));
		issue_command(build_req(CMD_POST, SLOTS - 1, 0, 0));
		issue_command(build_req(CMD_OPEN_NAMED, 0, -32768, 0));
		issue_command(build_req(CMD_WAIT, 0, 0, 5));
		issue_command(build_req(CMD_WAIT, 0, 0, 2));
		issue_command(build_req(CMD_WAIT, 3, 0, 5));
		issue_command(build_req(CMD_POST, 0, 0, TASKS - 1));
		issue_command(build_req(CMD_POST, 0, 0, 0));
		issue_command(build_req(CMD_POST, 3, 0, 0));
		issue_command(build_req(CMD_OPEN_NAMED, 0, 12, 1));
		issue_command(build_req(CMD_CLOSE, 0, 0, 0));
		issue_command(build_req(CMD_CLOSE, 0, 0, 0));
		issue_command(build_req(CMD_CLOSE, 0, 0, 0));
		issue_command(build_req(CMD_OPEN_FREE, SLOTS - 1, 100, 0));
		issue_command(build_req(CMD_OPEN_FREE, 0, -1, 0));
		for (int c = CMD_RSVD_LO; c <= CMD_RSVD_HI; c++) begin
			issue_command(build_req(3'(c), $urandom_range(0, SLOTS - 1), int'(rand_count()),
				$urandom_range(0, TASKS - 1)));
		end
		issue_command(build_req(CMD_WAIT, SLOTS - 1, 0, 0));
		issue_command(build_req(CMD_CLOSE, SLOTS - 1, 0, 0));
		issue_command(build_req(CMD_WAIT, 7, 0, TASKS - 1));
		issue_command(build_req(CMD_WAIT, 7, 0, TASKS - 1));
		issue_command(build_req(CMD_POST, 7, 0, 0));
	endtask

	task automatic test_table_full();
		repeat (SLOTS + 2) begin
			issue_command(build_req(CMD_OPEN_FREE, $urandom_range(0, SLOTS - 1),
				int'(rand_count()), $urandom_range(0, TASKS - 1)));
		end
		for (int s = 0; s < SLOTS; s++) begin
			while (refs_tbl[s] != 0) begin
				issue_command(build_req(CMD_CLOSE, s, int'(rand_count()),
					$urandom_range(0, TASKS - 1)));
			end
		end
	endtask

	task automatic test_ref_saturation();
		int s;
		s = $urandom_range(0, SLOTS - 1);
		repeat (258) begin
			issue_command(build_req(CMD_OPEN_NAMED, s, int'(rand_count()),
				$urandom_range(0, TASKS - 1)));
		end
		while (refs_tbl[s] != 0) begin
			issue_command(build_req(CMD_CLOSE, s, int'(rand_count()),
				$urandom_range(0, TASKS - 1)));
		end
		issue_command(build_req(CMD_CLOSE, s, int'(rand_count()), $urandom_range(0, TASKS - 1)));
	endtask

	// Most traffic goes to a few slots and tasks so that waits block and posts wake waiters.
	task automatic test_random_traffic(input int n);
		sem_req_t r;
		int       pick;
		for (int k = 0; k < n; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < 12) begin
				r.command = CMD_OPEN_NAMED;
			end else if (pick < 20) begin
				r.command = CMD_OPEN_FREE;
			end else if (pick < 35) begin
				r.command = CMD_CLOSE;
			end else if (pick < 65) begin
				r.command = CMD_WAIT;
			end else if (pick < 95) begin
				r.command = CMD_POST;
			end else begin
				r.command = 3'($urandom_range(CMD_RSVD_LO, CMD_RSVD_HI));
			end
			r.sem_index = ($urandom_range(0, 9) < 7) ? 5'($urandom_range(0, 3))
				: 5'($urandom_range(0, SLOTS - 1));
			r.initial_count = rand_count();
			r.task_id = ($urandom_range(0, 9) < 7) ? 6'($urandom_range(0, 7))
				: 6'($urandom_range(0, TASKS - 1));
			issue_command(r);
			if (k % 200 == 199) begin
				drain_results();
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			n_rsp++;
			if (rsp_due.size() == 0) begin
				n_mismatch++;
				if (n_mismatch <= 10) begin
					$display("result beat with nothing expected: err=%0d slot=%0d blk=%0d",
						result.error, result.slot_id, result.blocked);
					$display("  wv=%0d wt=%0d", result.woken_valid, result.woken_task);
				end
			end else begin
				want_rsp = rsp_due.pop_front();
				if (result.error !== want_rsp.error || result.slot_id !== want_rsp.slot_id
					|| result.blocked !== want_rsp.blocked
					|| result.woken_valid !== want_rsp.woken_valid
					|| result.woken_task !== want_rsp.woken_task) begin
					n_mismatch++;
					if (n_mismatch <= 10) begin
						$display("mismatch on result %0d: expected err=%0d slot=%0d blk=%0d",
							n_rsp, want_rsp.error, want_rsp.slot_id, want_rsp.blocked);
						$display("  expected wv=%0d wt=%0d", want_rsp.woken_valid,
							want_rsp.woken_task);
						$display("  got err=%0d slot=%0d blk=%0d wv=%0d wt=%0d",
							result.error, result.slot_id, result.blocked,
							result.woken_valid, result.woken_task);
					end
				end
				n_blocked += want_rsp.blocked;
				n_woken   += want_rsp.woken_valid;
				n_err_rsp += want_rsp.error;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || done || (start && !busy)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("no beat moved for %0d cycles, %0d results outstanding", IDLE_LIMIT,
				rsp_due.size());
			$display("tb_counting_semaphore_table_core: errors");
			$finish;
		end
	end

	initial begin
		arst_n      = 1'b0;
		start       = 1'b0;
		request     = '0;
		n_sent      = 0;
		n_rsp       = 0;
		n_blocked   = 0;
		n_woken     = 0;
		n_err_rsp   = 0;
		n_mismatch  = 0;
		idle_cycles = 0;
		burst_left  = 0;
		for (int i = 0; i < SLOTS; i++) begin
			count_tbl[i] = '0;
			refs_tbl[i]  = '0;
		end
		for (int i = 0; i < TASKS; i++) begin
			waiting_tbl[i]   = 1'b0;
			wait_slot_tbl[i] = '0;
		end
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed_cases();
		drain_results();
		test_table_full();
		test_ref_saturation();
		test_random_traffic(RANDOM_ITEMS);
		drain_results();
		repeat (10) @(posedge clk);
		$display("Sent %0d commands and checked %0d result beats.", n_sent, n_rsp);
		$display("Saw %0d blocking waits, %0d wakeups and %0d error responses.", n_blocked,
			n_woken, n_err_rsp);
		if (n_mismatch == 0) begin
			$display("tb_counting_semaphore_table_core: clean");
		end else begin
			$display("tb_counting_semaphore_table_core: errors");
		end
		$finish;
	end

endmodule

[files.f]
design/csem_pkg.sv
design/csem_ctrl.sv
design/csem_dp.sv
design/counting_semaphore_table_core.sv
tb/tb_counting_semaphore_table_core.sv
